// File: rtl/tmeb_pkg.sv
// ----------------------------------------------------------------------------
// tmeb_pkg
// Shared types, codes and defaults for the timestamp merge event builder.
// ----------------------------------------------------------------------------
package tmeb_pkg;

  localparam int NUM_SOURCES_DEF    = 8;
  localparam int MAX_EVENT_HITS_DEF = 65536;

  localparam int SRC_W   = 3;
  localparam int TIME_W  = 48;
  localparam int NS_W    = 52;
  localparam int WIN_W   = 31;
  localparam int SCALE_W = 4;
  localparam int CNT_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUILD_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE   = 2'd2;

  localparam logic [WIN_W-1:0]   TIME_WINDOW_RST  = '0;
  localparam logic               BUILD_ENABLE_RST = 1'b1;
  localparam logic [SCALE_W-1:0] TICK_SCALE_RST   = 4'd2;

  localparam logic OP_HIT    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic [7:0]      board_id;
    logic [15:0]     serial_number;
    logic [5:0]      channel;
    logic [15:0]     energy;
    logic [15:0]     short_energy;
    logic [NS_W-1:0] time_ns;
    logic [15:0]     fine_time_ns;
    logic [15:0]     flags_low;
    logic [15:0]     flags_high;
    logic [31:0]     event_number;
    logic [15:0]     hit_index;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic mul;
    logic evt;
    logic xfer;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic scan_last;
    logic res_keep;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// File: rtl/tmeb_ctrl.sv
// ----------------------------------------------------------------------------
// tmeb_ctrl
// Sequencer: accepts one transaction, then scans, scales, groups and hands
// out the merged hits until the merge has to wait for more input.
// ----------------------------------------------------------------------------
module tmeb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmeb_pkg::status_t status,
  output tmeb_pkg::cmd_t    cmd
);
  import tmeb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_EVT   = 7'b0010000,
    S_XFER  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.emit_ok) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EVT;
      end
      S_EVT: begin
        cmd.evt    = 1'b1;
        state_next = S_XFER;
      end
      S_XFER: begin
        if (!status.res_keep) begin
          state_next = S_CHECK;
        end else if (!status.pend_valid || status.out_free) begin
          cmd.xfer   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/tmeb_dp.sv
// ----------------------------------------------------------------------------
// tmeb_dp
// Datapath: head slots, earliest-head scan, tick scaling, event grouping,
// one pending result and the output register.
// ----------------------------------------------------------------------------
module tmeb_dp #(
  parameter int NUM_SOURCES    = tmeb_pkg::NUM_SOURCES_DEF,
  parameter int MAX_EVENT_HITS = tmeb_pkg::MAX_EVENT_HITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tmeb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmeb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                operation,
  input  logic [tmeb_pkg::SRC_W-1:0]          source_index,
  input  logic [7:0]                          board_id,
  input  logic [15:0]                         serial_number,
  input  logic [5:0]                          channel,
  input  logic [15:0]                         energy,
  input  logic [15:0]                         short_energy,
  input  logic [tmeb_pkg::TIME_W-1:0]         coarse_time,
  input  logic [15:0]                         fine_time,
  input  logic [15:0]                         flags_low,
  input  logic [15:0]                         flags_high,
  input  tmeb_pkg::cmd_t                      cmd,
  output tmeb_pkg::status_t                   status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output tmeb_pkg::result_t                   out_rec,
  output logic                                out_last
);
  import tmeb_pkg::*;

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);
  localparam logic [CNT_W-1:0] MAX_HITS = CNT_W'(MAX_EVENT_HITS);

  // configuration
  logic [WIN_W-1:0]   time_window;
  logic               build_enable;
  logic [SCALE_W-1:0] tick_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_window  <= TIME_WINDOW_RST;
      build_enable <= BUILD_ENABLE_RST;
      tick_scale   <= TICK_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIME_WINDOW:  time_window  <= cfg_data[WIN_W-1:0];
        CFG_BUILD_ENABLE: build_enable <= cfg_data[0];
        CFG_TICK_SCALE:   tick_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // head slots
  logic [TIME_W-1:0] head_time     [NUM_SOURCES];
  logic [47:0]       head_energies [NUM_SOURCES];
  logic [31:0]       head_flags    [NUM_SOURCES];
  logic [29:0]       head_ident    [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] head_full;
  logic [NUM_SOURCES-1:0] source_finished;

  logic [IDX_W-1:0] wr_idx;
  logic             in_range;
  assign wr_idx   = IDX_W'(source_index);
  assign in_range = int'(source_index) < NUM_SOURCES;

  // scan state
  logic [IDX_W-1:0]  sidx;
  logic              best_valid;
  logic [IDX_W-1:0]  best_src;
  logic [TIME_W-1:0] best_time;
  logic [47:0]       best_energies;
  logic [31:0]       best_flags;
  logic [29:0]       best_ident;

  always_ff @(posedge clk) begin
    if (cmd.load && in_range && !source_finished[wr_idx] && operation == OP_HIT
        && !head_full[wr_idx]) begin
      head_time[wr_idx]     <= coarse_time;
      head_energies[wr_idx] <= {fine_time, short_energy, energy};
      head_flags[wr_idx]    <= {flags_high, flags_low};
      head_ident[wr_idx]    <= {board_id, serial_number, channel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_full       <= '0;
      source_finished <= '0;
    end else begin
      if (cmd.load && in_range && !source_finished[wr_idx]) begin
        if (operation == OP_FINISH) source_finished[wr_idx] <= 1'b1;
        else head_full[wr_idx] <= 1'b1;
      end
      if (cmd.mul) head_full[best_src] <= 1'b0;
    end
  end

  // ties go to the later source, so <= keeps the highest index
  always_ff @(posedge clk) begin
    if (rst) begin
      sidx       <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_init) begin
      sidx       <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      sidx <= sidx + 1'b1;
      if (head_full[sidx] && (!best_valid || head_time[sidx] <= best_time)) begin
        best_valid    <= 1'b1;
        best_src      <= sidx;
        best_time     <= head_time[sidx];
        best_energies <= head_energies[sidx];
        best_flags    <= head_flags[sidx];
        best_ident    <= head_ident[sidx];
      end
    end
  end

  // scaled times
  logic [NS_W-1:0] t_ns;
  logic [15:0]     fine_ns;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      t_ns    <= {{(NS_W-TIME_W){1'b0}}, best_time} * {{(NS_W-SCALE_W){1'b0}}, tick_scale};
      fine_ns <= 16'(best_energies[47:32] * tick_scale);
    end
  end

  // event grouping
  logic [NS_W-1:0]  event_first_time;
  logic [31:0]      event_counter;
  logic [CNT_W-1:0] event_hit_count;
  logic             event_open;
  logic [NS_W-1:0]  diff;
  logic             joins;
  result_t          res;
  logic             res_keep;

  assign diff  = t_ns - event_first_time;
  assign joins = build_enable && (diff < NS_W'(time_window));

  always_ff @(posedge clk) begin
    if (rst) begin
      event_first_time <= '0;
      event_counter    <= '0;
      event_hit_count  <= '0;
      event_open       <= 1'b0;
      res_keep         <= 1'b0;
    end else if (cmd.evt) begin
      res_keep <= 1'b1;
      if (!event_open) begin
        event_open       <= 1'b1;
        event_first_time <= t_ns;
        event_hit_count  <= CNT_W'(1);
      end else if (joins) begin
        if (event_hit_count >= MAX_HITS) res_keep <= 1'b0;
        else event_hit_count <= event_hit_count + 1'b1;
      end else begin
        event_counter    <= event_counter + 1'b1;
        event_first_time <= t_ns;
        event_hit_count  <= CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evt) begin
      res.board_id      <= best_ident[29:22];
      res.serial_number <= best_ident[21:6];
      res.channel       <= best_ident[5:0];
      res.energy        <= best_energies[15:0];
      res.short_energy  <= best_energies[31:16];
      res.time_ns       <= t_ns;
      res.fine_time_ns  <= fine_ns;
      res.flags_low     <= best_flags[15:0];
      res.flags_high    <= best_flags[31:16];
      if (event_open && joins) begin
        res.event_number <= event_counter;
        res.hit_index    <= event_hit_count[15:0];
      end else begin
        res.event_number <= event_open ? event_counter + 1'b1 : event_counter;
        res.hit_index    <= '0;
      end
    end
  end

  // pending result waits until we know whether another one follows
  result_t pend;
  logic    pend_valid;
  logic    out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      if ((cmd.xfer && pend_valid) || cmd.flush) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.xfer) begin
        pend       <= res;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_rec  <= pend;
          out_last <= 1'b0;
        end
      end else if (cmd.flush) begin
        out_rec    <= pend;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  assign status.emit_ok    = (&(head_full | source_finished)) && (|head_full);
  assign status.scan_last  = sidx == LAST_IDX;
  assign status.res_keep   = res_keep;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

endmodule

// File: rtl/timestamp_merge_event_builder.sv
// ----------------------------------------------------------------------------
// timestamp_merge_event_builder
// Time-ordered merge of per-source hit streams with window event building.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transaction carries either a hit of
// one source or a finish mark for it. Each source holds one head hit. While
// every source holds a head or is finished, the earliest head (highest source
// on a tie) is scaled by tick_scale, tagged with event_number and hit_index,
// and sent on the output channel (out_valid/out_ready); last marks the final
// result caused by an input transaction.
// One input transaction at a time: the block accepts it and checks the heads,
// then per emitted hit scans the sources in sequence, scales, groups, hands
// the result off and checks again, then closes the transaction.
// Configuration (cfg_valid/cfg_index/cfg_data) is ready outside reset and
// must be written only while the block is idle, which it does not enforce.
// Reset clears heads, finish marks, event state and restores register
// defaults. A stalled receiver holds the output register; work stops at the
// next hand-off until it drains.
// ----------------------------------------------------------------------------
module timestamp_merge_event_builder #(
  parameter int NUM_SOURCES    = tmeb_pkg::NUM_SOURCES_DEF,
  parameter int MAX_EVENT_HITS = tmeb_pkg::MAX_EVENT_HITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmeb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmeb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [tmeb_pkg::SRC_W-1:0]      source_index,
  input  logic [7:0]                      board_id,
  input  logic [15:0]                     serial_number,
  input  logic [5:0]                      channel,
  input  logic [15:0]                     energy,
  input  logic [15:0]                     short_energy,
  input  logic [tmeb_pkg::TIME_W-1:0]     coarse_time,
  input  logic [15:0]                     fine_time,
  input  logic [15:0]                     flags_low,
  input  logic [15:0]                     flags_high,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_board_id,
  output logic [15:0]                     out_serial_number,
  output logic [5:0]                      out_channel,
  output logic [15:0]                     out_energy,
  output logic [15:0]                     out_short_energy,
  output logic [tmeb_pkg::NS_W-1:0]       time_ns,
  output logic [15:0]                     fine_time_ns,
  output logic [15:0]                     out_flags_low,
  output logic [15:0]                     out_flags_high,
  output logic [31:0]                     event_number,
  output logic [15:0]                     hit_index,
  output logic                            last
);
  import tmeb_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t out_rec;

  assign cfg_ready = !rst;

  tmeb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmeb_dp #(
    .NUM_SOURCES    (NUM_SOURCES),
    .MAX_EVENT_HITS (MAX_EVENT_HITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .source_index  (source_index),
    .board_id      (board_id),
    .serial_number (serial_number),
    .channel       (channel),
    .energy        (energy),
    .short_energy  (short_energy),
    .coarse_time   (coarse_time),
    .fine_time     (fine_time),
    .flags_low     (flags_low),
    .flags_high    (flags_high),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_rec       (out_rec),
    .out_last      (last)
  );

  assign out_board_id      = out_rec.board_id;
  assign out_serial_number = out_rec.serial_number;
  assign out_channel       = out_rec.channel;
  assign out_energy        = out_rec.energy;
  assign out_short_energy  = out_rec.short_energy;
  assign time_ns           = out_rec.time_ns;
  assign fine_time_ns      = out_rec.fine_time_ns;
  assign out_flags_low     = out_rec.flags_low;
  assign out_flags_high    = out_rec.flags_high;
  assign event_number      = out_rec.event_number;
  assign hit_index         = out_rec.hit_index;

endmodule
